FILE: rtl/bmi_pkg.sv
// Shared types and helper functions for the bitmask immediate / bitfield unit.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package bmi_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned FieldW = 6;

  typedef enum logic {
    REQ_LOGICAL  = 1'b0,
    REQ_BITFIELD = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic              req_type;
    logic [DataW-1:0]  operand;
    logic              imm_n;
    logic [FieldW-1:0] imm_s;
    logic [FieldW-1:0] imm_r;
    logic              wide;
  } bmi_req_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             undefined_encoding;
    logic [DataW-1:0] wide_mask;
    logic [DataW-1:0] top_mask;
  } bmi_rsp_t;

  // Decoded masks handed from the decoder to the datapath.
  typedef struct packed {
    logic [DataW-1:0] wmask;
    logic [DataW-1:0] tmask;
    logic             bad;
  } bmi_masks_t;

  // Run of cnt ones at the bottom of a word; cnt is 1 to 64.
  function automatic logic [DataW-1:0] ones_mask(input logic [FieldW:0] cnt);
    logic [FieldW:0] sh;
    sh = 7'(DataW) - cnt;
    return {DataW{1'b1}} >> sh;
  endfunction

  // Rotate a 64-bit word right.
  function automatic logic [DataW-1:0] ror64(input logic [DataW-1:0] x,
                                             input logic [FieldW-1:0] sh);
    logic [2*DataW-1:0] tmp;
    tmp = {x, x} >> sh;
    return tmp[DataW-1:0];
  endfunction

  // Rotate a 32-bit word right.
  function automatic logic [HalfW-1:0] ror32(input logic [HalfW-1:0] x,
                                             input logic [FieldW-2:0] sh);
    logic [2*HalfW-1:0] tmp;
    tmp = {x, x} >> sh;
    return tmp[HalfW-1:0];
  endfunction

  // Replicate the low 2**len bits of x across the whole word for len 1 to 6; any other len gives zero.
  function automatic logic [DataW-1:0] spread(input logic [DataW-1:0] x,
                                              input logic [2:0] len);
    logic [DataW-1:0] acc;
    case (len)
      3'd1:    acc = {32{x[1:0]}};
      3'd2:    acc = {16{x[3:0]}};
      3'd3:    acc = {8{x[7:0]}};
      3'd4:    acc = {4{x[15:0]}};
      3'd5:    acc = {2{x[31:0]}};
      3'd6:    acc = x;
      default: acc = '0;
    endcase
    return acc;
  endfunction

endpackage

FILE: rtl/bmi_decode.sv
// Bitmask immediate decoder: element size, wmask, tmask and illegal-encoding check.
// Depends on bmi_pkg.
`timescale 1ns / 1ps

module bmi_decode (
  input  bmi_pkg::bmi_req_t   req,
  output bmi_pkg::bmi_masks_t masks
);

  logic [6:0]                   key;
  logic [2:0]                   len;
  logic [bmi_pkg::FieldW-1:0]   lv;
  logic [bmi_pkg::FieldW-1:0]   s;
  logic [bmi_pkg::FieldW-1:0]   r;
  logic [bmi_pkg::FieldW-1:0]   d;
  logic [bmi_pkg::DataW-1:0]    width_mask;
  logic [bmi_pkg::DataW-1:0]    welem;
  logic                         bad;

  assign key = {req.imm_n, ~req.imm_s};

  // Highest set bit of N:NOT(imms) gives log2 of the element size.
  always_comb begin
    if (key[6])      len = 3'd6;
    else if (key[5]) len = 3'd5;
    else if (key[4]) len = 3'd4;
    else if (key[3]) len = 3'd3;
    else if (key[2]) len = 3'd2;
    else if (key[1]) len = 3'd1;
    else             len = 3'd0;
  end

  assign lv = 6'((7'd1 << len) - 7'd1);
  assign s  = req.imm_s & lv;
  assign r  = req.imm_r & lv;
  assign d  = (s - r) & lv;

  assign width_mask = req.wide ? {bmi_pkg::DataW{1'b1}}
                               : {{bmi_pkg::HalfW{1'b0}}, {bmi_pkg::HalfW{1'b1}}};

  always_comb begin
    bad = (len == 3'd0);
    if (req.req_type == bmi_pkg::REQ_LOGICAL) begin
      if (!req.wide && req.imm_n) bad = 1'b1;
      if (s == lv)                bad = 1'b1;
    end else begin
      if (req.wide && !req.imm_n) bad = 1'b1;
      if (!req.wide && (req.imm_n || req.imm_r[5] || req.imm_s[5])) bad = 1'b1;
    end
  end

  // The replicated pattern has period esize and r < esize, so rotating the
  // whole word equals rotating each element.
  assign welem = bmi_pkg::spread(bmi_pkg::ones_mask({1'b0, s} + 7'd1), len);

  always_comb begin
    masks.bad = bad;
    if (bad) begin
      masks.wmask = '0;
      masks.tmask = '0;
    end else begin
      masks.wmask = bmi_pkg::ror64(welem, r) & width_mask;
      masks.tmask = bmi_pkg::spread(bmi_pkg::ones_mask({1'b0, d} + 7'd1), len)
                    & width_mask;
    end
  end

endmodule

FILE: rtl/bmi_datapath.sv
// Operand datapath: rotate for the bitfield move, masking and width truncation.
// Depends on bmi_pkg; takes its masks from bmi_decode.
`timescale 1ns / 1ps

module bmi_datapath (
  input  bmi_pkg::bmi_req_t   req,
  input  bmi_pkg::bmi_masks_t masks,
  output bmi_pkg::bmi_rsp_t   rsp
);

  logic [bmi_pkg::DataW-1:0] rotated;
  logic [bmi_pkg::DataW-1:0] value;

  always_comb begin
    if (req.wide) begin
      rotated = bmi_pkg::ror64(req.operand, req.imm_r);
    end else begin
      rotated = {{bmi_pkg::HalfW{1'b0}},
                 bmi_pkg::ror32(req.operand[bmi_pkg::HalfW-1:0],
                                req.imm_r[bmi_pkg::FieldW-2:0])};
    end
  end

  // Masks are already truncated to the operation width and zero when illegal.
  always_comb begin
    if (req.req_type == bmi_pkg::REQ_LOGICAL) begin
      value = req.operand & masks.wmask;
    end else begin
      value = rotated & masks.wmask & masks.tmask;
    end
  end

  assign rsp.result             = value;
  assign rsp.undefined_encoding = masks.bad;
  assign rsp.wide_mask          = masks.wmask;
  assign rsp.top_mask           = masks.tmask;

endmodule

FILE: rtl/bitmask_immediate_bitfield_unit.sv
// A request accepted at a rising edge is held in the input register; its result is then registered in the
// result register and shown on rsp, with done high for a single cycle.
// Throughput: one request per cycle; busy is never raised, the unit is fully pipelined
// through an input register and a result register with the decode and masking between.
// Reset: synchronous active-high rst clears both valid flags; payload registers are not reset.
// The receiver cannot stall: done marks each result on rsp for exactly one cycle.
`timescale 1ns / 1ps

module bitmask_immediate_bitfield_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bmi_pkg::bmi_req_t req,
  output logic              done,
  output bmi_pkg::bmi_rsp_t rsp
);

  logic                in_valid;
  bmi_pkg::bmi_req_t   in_req;
  bmi_pkg::bmi_masks_t masks;
  bmi_pkg::bmi_rsp_t   rsp_next;
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= accept;
      done     <= in_valid;
    end
    if (accept) in_req <= req;
    if (in_valid) rsp <= rsp_next;
  end

  bmi_decode u_decode (
    .req   (in_req),
    .masks (masks)
  );

  bmi_datapath u_datapath (
    .req   (in_req),
    .masks (masks),
    .rsp   (rsp_next)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("request not answered two cycles after acceptance");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2) && !$past(rst, 2))
    else $error("done without a matching request");

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.undefined_encoding) |->
      (rsp.result == '0 && rsp.wide_mask == '0 && rsp.top_mask == '0))
    else $error("illegal encoding produced nonzero outputs");

  a_result_in_mask: assert property (@(posedge clk) disable iff (rst)
    done |-> ((rsp.result & ~rsp.wide_mask) == '0))
    else $error("result has bits outside wmask");

endmodule
